>>> design/icmp_erf_pkg.sv
// Package for the ICMP echo reply filter.
// Holds verdict codes and ICMP header byte offsets; no dependencies.
package icmp_erf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned SEQ_W  = 16;
	localparam int unsigned HLEN_W = 6;

	typedef logic [1:0] verdict_t;

	localparam verdict_t VERDICT_ACCEPTED  = 2'd0;
	localparam verdict_t VERDICT_TOO_SHORT = 2'd1;
	localparam verdict_t VERDICT_NOT_REPLY = 2'd2;
	localparam verdict_t VERDICT_FOREIGN   = 2'd3;

	// Byte offsets within the ICMP header.
	localparam int unsigned OFS_TYPE   = 0;
	localparam int unsigned OFS_ID_HI  = 4;
	localparam int unsigned OFS_ID_LO  = 5;
	localparam int unsigned OFS_SEQ_HI = 6;
	localparam int unsigned OFS_SEQ_LO = 7;
	localparam int unsigned ICMP_HDR_BYTES = 8;

	// Type code of an echo reply.
	localparam logic [BYTE_W-1:0] ICMP_TYPE_ECHO_REPLY = 8'd0;

endpackage

>>> design/icmp_erf_byte_if.sv
// Byte stream channel into the ICMP echo reply filter.
// Depends on icmp_erf_pkg for the byte width.
interface icmp_erf_byte_if
	import icmp_erf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packet_byte;
	logic              last_byte;

	modport source (output valid, output packet_byte, output last_byte, input ready);
	modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

>>> design/icmp_erf_result_if.sv
// Result channel out of the ICMP echo reply filter.
// Depends on icmp_erf_pkg for the verdict type and sequence width.
interface icmp_erf_result_if
	import icmp_erf_pkg::*;
#(
	parameter int unsigned LEN_W = 17
) ();
	logic             valid;
	logic             ready;
	verdict_t         verdict;
	logic [SEQ_W-1:0] sequence_number;
	logic [LEN_W-1:0] packet_length;

	modport source (output valid, output verdict, output sequence_number,
		output packet_length, input ready);
	modport sink   (input valid, input verdict, input sequence_number,
		input packet_length, output ready);
endinterface

>>> design/icmp_echo_reply_filter.sv
// ICMP echo reply filter. Takes an IPv4 packet one byte per request and, on the byte
// marked last, returns one verdict (accepted, too short, not an echo reply, foreign
// identifier) with the sequence number (zero unless accepted) and the saturated packet
// length. Throughput is one byte per clock with no gaps between packets. A byte passes
// through the input register; the verdict for the last byte is loaded from there into
// the result register, which presents it to the receiver. Input stalls only when a last
// byte sits in the input register while the result register holds a verdict that the
// receiver is not taking in that cycle.
// Depends on icmp_erf_pkg and the interfaces icmp_erf_byte_if and icmp_erf_result_if.
module icmp_echo_reply_filter
	import icmp_erf_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = 65544,
	parameter int unsigned LEN_W = $clog2(MAX_PACKET_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [ID_W-1:0]    cfg_wr_data,
	icmp_erf_byte_if.sink      pkt,
	icmp_erf_result_if.source  res
);

	localparam int unsigned CMP_W = (LEN_W > HLEN_W + 1) ? LEN_W : HLEN_W + 1;

	// Configuration register.
	logic [ID_W-1:0] own_identifier_q;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Per-packet state.
	logic [LEN_W-1:0]  byte_count_q;
	logic [HLEN_W-1:0] header_length_q;
	logic              type_is_reply_q;
	logic              identifier_match_q;
	logic [SEQ_W-1:0]  sequence_store_q;

	// Result register.
	logic             out_valid_q;
	verdict_t         verdict_q;
	logic [SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0] len_q;

	logic out_free;
	logic s1_fire;

	logic [LEN_W-1:0]  count_nxt;
	logic [HLEN_W-1:0] hlen_nxt;
	logic              reply_nxt;
	logic              match_nxt;
	logic [SEQ_W-1:0]  seq_nxt;
	logic              counted;
	logic [CMP_W-1:0]  idx_w;
	logic [CMP_W-1:0]  hlen_w;
	logic [CMP_W-1:0]  offset;
	verdict_t          verdict_d;

	assign out_free  = !out_valid_q || res.ready;
	// A byte that closes a packet may only leave stage 1 when the result slot is free.
	assign s1_fire   = valid_s1 && (!last_s1 || out_free);
	assign pkt.ready = !valid_s1 || s1_fire;

	always_comb begin
		count_nxt = byte_count_q;
		hlen_nxt  = header_length_q;
		reply_nxt = type_is_reply_q;
		match_nxt = identifier_match_q;
		seq_nxt   = sequence_store_q;
		counted   = byte_count_q < LEN_W'(MAX_PACKET_BYTES);
		idx_w     = CMP_W'(byte_count_q);
		if (counted) begin
			count_nxt = byte_count_q + LEN_W'(1);
			if (byte_count_q == '0) begin
				hlen_nxt = {byte_s1[3:0], 2'b00};
			end
		end
		hlen_w = CMP_W'(hlen_nxt);
		offset = idx_w - hlen_w;
		// Bytes past the saturation point or inside the IP header are not examined.
		if (counted && idx_w >= hlen_w) begin
			if (offset == CMP_W'(OFS_TYPE)) begin
				reply_nxt = byte_s1 == ICMP_TYPE_ECHO_REPLY;
			end else if (offset == CMP_W'(OFS_ID_HI)) begin
				match_nxt = byte_s1 == own_identifier_q[ID_W-1 -: BYTE_W];
			end else if (offset == CMP_W'(OFS_ID_LO)) begin
				match_nxt = identifier_match_q && (byte_s1 == own_identifier_q[BYTE_W-1:0]);
			end else if (offset == CMP_W'(OFS_SEQ_HI)) begin
				seq_nxt = {byte_s1, BYTE_W'(0)};
			end else if (offset == CMP_W'(OFS_SEQ_LO)) begin
				seq_nxt = {sequence_store_q[SEQ_W-1 -: BYTE_W], byte_s1};
			end
		end

		if (CMP_W'(count_nxt) < hlen_w + CMP_W'(ICMP_HDR_BYTES)) begin
			verdict_d = VERDICT_TOO_SHORT;
		end else if (!reply_nxt) begin
			verdict_d = VERDICT_NOT_REPLY;
		end else if (!match_nxt) begin
			verdict_d = VERDICT_FOREIGN;
		end else begin
			verdict_d = VERDICT_ACCEPTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_identifier_q <= '0;
		end else if (cfg_wr_en) begin
			own_identifier_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			byte_s1 <= pkt.packet_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q       <= '0;
			header_length_q    <= '0;
			type_is_reply_q    <= 1'b0;
			identifier_match_q <= 1'b0;
			sequence_store_q   <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				byte_count_q       <= '0;
				header_length_q    <= '0;
				type_is_reply_q    <= 1'b0;
				identifier_match_q <= 1'b0;
				sequence_store_q   <= '0;
			end else begin
				byte_count_q       <= count_nxt;
				header_length_q    <= hlen_nxt;
				type_is_reply_q    <= reply_nxt;
				identifier_match_q <= match_nxt;
				sequence_store_q   <= seq_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			verdict_q <= verdict_d;
			seq_q     <= (verdict_d == VERDICT_ACCEPTED) ? seq_nxt : '0;
			len_q     <= count_nxt;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.verdict         = verdict_q;
	assign res.sequence_number = seq_q;
	assign res.packet_length   = len_q;

endmodule
